FILE: src/teq_pkg.sv
// ----------------------------------------------------------------------------
// Timed event queue package
// Shared codes, defaults and the link bundle passed between queue cells.
// ----------------------------------------------------------------------------
package teq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int ID_BITS_DEF   = 8;
  localparam int TIME_BITS_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 3;
  localparam int OP_W     = 3;

  // input modes
  localparam logic [MODE_W-1:0] MODE_ADD_AT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_AFTER  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CANCEL     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CANCEL_ALL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK       = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_FIRED     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_CANCELLED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_NONE      = 3'd6;

  // operations broadcast to every cell
  localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
  localparam logic [OP_W-1:0] OP_PROBE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_POP    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  // flags a cell hands to its right-hand neighbor; valid also goes to the left-hand one
  typedef struct packed {
    logic valid;  // cell holds an event
    logic gt;     // cell due time is later than the broadcast due time
    logic rem;    // the cancelled event sits in this cell or further left
  } link_t;

endpackage

FILE: src/teq_cell.sv
// ----------------------------------------------------------------------------
// Timed event queue cell
// One slot of the sorted row: holds an event and shifts with its neighbors.
// ----------------------------------------------------------------------------
module teq_cell #(
  parameter int ID_BITS   = teq_pkg::ID_BITS_DEF,
  parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [teq_pkg::OP_W-1:0] op,
  input  logic [ID_BITS-1:0]       cmd_id,
  input  logic [TIME_BITS-1:0]     cmd_due,
  input  teq_pkg::link_t           left_link,
  input  logic [ID_BITS-1:0]       left_id,
  input  logic [TIME_BITS-1:0]     left_due,
  input  teq_pkg::link_t           right_link,
  input  logic [ID_BITS-1:0]       right_id,
  input  logic [TIME_BITS-1:0]     right_due,
  output teq_pkg::link_t           link,
  output logic [ID_BITS-1:0]       id,
  output logic [TIME_BITS-1:0]     due,
  output logic                     hit
);

  logic valid;
  logic gt_self;
  logic rem_here;
  logic take_left;
  logic take_new;
  logic take_right;

  assign gt_self  = valid && (due > cmd_due);
  assign rem_here = left_link.rem || hit;

  assign link.valid = valid;
  assign link.gt    = gt_self;
  assign link.rem   = rem_here;

  always_comb begin
    take_left  = 1'b0;
    take_new   = 1'b0;
    take_right = 1'b0;
    case (op)
      teq_pkg::OP_INSERT: begin
        // later events move right; the new one lands at the first later or empty slot
        if (!valid || gt_self) begin
          if (left_link.gt) begin
            take_left = 1'b1;
          end else if (left_link.valid) begin
            take_new = 1'b1;
          end
        end
      end
      teq_pkg::OP_REMOVE: take_right = rem_here;
      teq_pkg::OP_POP:    take_right = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      case (op)
        teq_pkg::OP_PROBE: hit <= valid && (id == cmd_id);
        teq_pkg::OP_CLEAR: begin
          valid <= 1'b0;
          hit   <= 1'b0;
        end
        teq_pkg::OP_REMOVE: hit <= 1'b0;
        default: ;
      endcase
      if (take_left || take_new) begin
        valid <= 1'b1;
      end else if (take_right) begin
        valid <= right_link.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_left) begin
      id  <= left_id;
      due <= left_due;
    end else if (take_new) begin
      id  <= cmd_id;
      due <= cmd_due;
    end else if (take_right) begin
      id  <= right_id;
      due <= right_due;
    end
  end

endmodule

FILE: src/timed_event_queue.sv
// ----------------------------------------------------------------------------
// Timed event queue
// Sorted row of pending events with a saturating time counter and ticks.
// ----------------------------------------------------------------------------
//
//  port group | direction | tdata                  | tuser  | tlast
//  s_*        | in        | event_id, time_value   | mode   | -
//  m_*        | out       | event_id_res, due_time | status | last
//
// Add, cancel and cancel-all pass through an accept step (id compare in every
// cell, delay sum) and a commit step (at most one shift or a clear of the row,
// result written). A tick gives at least one result after its accept; each
// fired event pops the head cell, so the whole row moves left once per cycle.
// Reset empties the row at once through the per-cell valid flops.
// A stalled output holds the commit or pop until the result register frees.
//
module timed_event_queue #(
  parameter int DEPTH     = teq_pkg::DEPTH_DEF,
  parameter int ID_BITS   = teq_pkg::ID_BITS_DEF,
  parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
  localparam int DATA_W   = ((ID_BITS + TIME_BITS + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [DATA_W-1:0]            s_tdata,   // event_id, time_value, zero pad
  input  logic [teq_pkg::MODE_W-1:0]   s_tuser,   // mode
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [DATA_W-1:0]            m_tdata,   // event_id_res, due_time, zero pad
  output logic [teq_pkg::STATUS_W-1:0] m_tuser,   // status
  output logic                         m_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [teq_pkg::MODE_W-1:0]   mode_q;
  logic [ID_BITS-1:0]           id_q;
  logic [TIME_BITS-1:0]         due_q;
  logic [TIME_BITS-1:0]         cur_time;

  logic [ID_BITS-1:0]           in_id;
  logic [TIME_BITS-1:0]         in_time;
  logic [TIME_BITS:0]           delay_sum;
  logic [TIME_BITS-1:0]         due_req;
  logic                         in_accept;
  logic                         out_free;

  logic [teq_pkg::OP_W-1:0]     cell_op;
  logic [ID_BITS-1:0]           cmd_id;
  teq_pkg::link_t               links [DEPTH];
  logic [ID_BITS-1:0]           cell_id [DEPTH];
  logic [TIME_BITS-1:0]         cell_due [DEPTH];
  logic [DEPTH-1:0]             cell_hit;
  logic [DEPTH-1:0]             cell_valid;

  logic                         hit_any;
  logic [TIME_BITS-1:0]         hit_due;
  logic                         full;
  logic                         head_due;
  logic                         second_due;

  logic                         out_load;
  logic [teq_pkg::STATUS_W-1:0] out_status;
  logic [ID_BITS-1:0]           out_id;
  logic [TIME_BITS-1:0]         out_due;
  logic                         out_last;

  assign in_id     = s_tdata[ID_BITS-1:0];
  assign in_time   = s_tdata[ID_BITS +: TIME_BITS];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign delay_sum = {1'b0, cur_time} + {1'b0, in_time};
  assign due_req   = (s_tuser == teq_pkg::MODE_ADD_AFTER)
                   ? (delay_sum[TIME_BITS] ? TIME_MAX : delay_sum[TIME_BITS-1:0])
                   : in_time;

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    teq_pkg::link_t        left_link;
    logic [ID_BITS-1:0]    left_id;
    logic [TIME_BITS-1:0]  left_due;
    teq_pkg::link_t        right_link;
    logic [ID_BITS-1:0]    right_id;
    logic [TIME_BITS-1:0]  right_due;

    if (i == 0) begin : g_head
      assign left_link = '{valid: 1'b1, gt: 1'b0, rem: 1'b0};
      assign left_id   = '0;
      assign left_due  = '0;
    end else begin : g_body
      assign left_link = links[i-1];
      assign left_id   = cell_id[i-1];
      assign left_due  = cell_due[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_link = '{valid: 1'b0, gt: 1'b0, rem: 1'b0};
      assign right_id   = '0;
      assign right_due  = '0;
    end else begin : g_inner
      assign right_link = links[i+1];
      assign right_id   = cell_id[i+1];
      assign right_due  = cell_due[i+1];
    end

    teq_cell #(
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (cell_op),
      .cmd_id     (cmd_id),
      .cmd_due    (due_q),
      .left_link  (left_link),
      .left_id    (left_id),
      .left_due   (left_due),
      .right_link (right_link),
      .right_id   (right_id),
      .right_due  (right_due),
      .link       (links[i]),
      .id         (cell_id[i]),
      .due        (cell_due[i]),
      .hit        (cell_hit[i])
    );

    assign cell_valid[i] = links[i].valid;
  end

  always_comb begin
    hit_due = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_due = hit_due | (cell_hit[i] ? cell_due[i] : '0);
    end
  end

  assign hit_any    = |cell_hit;
  assign full       = cell_valid[DEPTH-1];
  assign head_due   = cell_valid[0] && (cell_due[0] <= cur_time);
  assign second_due = cell_valid[1] && (cell_due[1] <= cur_time);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    cell_op    = teq_pkg::OP_NOP;
    cmd_id     = id_q;
    out_load   = 1'b0;
    out_status = teq_pkg::STAT_NONE;
    out_id     = '0;
    out_due    = '0;
    out_last   = 1'b1;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          cell_op = teq_pkg::OP_PROBE;
          cmd_id  = in_id;
          if (s_tuser == teq_pkg::MODE_TICK) begin
            state_next = ST_TICK;
          end else if (s_tuser inside {teq_pkg::MODE_ADD_AT, teq_pkg::MODE_ADD_AFTER,
                                       teq_pkg::MODE_CANCEL, teq_pkg::MODE_CANCEL_ALL}) begin
            state_next = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          out_id     = id_q;
          case (mode_q)
            teq_pkg::MODE_CANCEL: begin
              if (hit_any) begin
                cell_op    = teq_pkg::OP_REMOVE;
                out_status = teq_pkg::STAT_CANCELLED;
                out_due    = hit_due;
              end else begin
                out_status = teq_pkg::STAT_NOT_FOUND;
              end
            end
            teq_pkg::MODE_CANCEL_ALL: begin
              cell_op    = teq_pkg::OP_CLEAR;
              out_status = teq_pkg::STAT_NONE;
              out_id     = '0;
            end
            default: begin
              // duplicate wins over full
              if (hit_any) begin
                out_status = teq_pkg::STAT_DUPLICATE;
                out_due    = hit_due;
              end else if (full) begin
                out_status = teq_pkg::STAT_FULL;
                out_due    = due_q;
              end else begin
                cell_op    = teq_pkg::OP_INSERT;
                out_status = teq_pkg::STAT_ADDED;
                out_due    = due_q;
              end
            end
          endcase
        end
      end
      ST_TICK: begin
        if (out_free) begin
          out_load = 1'b1;
          if (head_due) begin
            cell_op    = teq_pkg::OP_POP;
            out_status = teq_pkg::STAT_FIRED;
            out_id     = cell_id[0];
            out_due    = cell_due[0];
            out_last   = !second_due;
          end
          if (!head_due || !second_due) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur_time <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept && (s_tuser == teq_pkg::MODE_TICK) && (cur_time != TIME_MAX)) begin
        cur_time <= cur_time + 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q <= s_tuser;
      id_q   <= in_id;
      due_q  <= due_req;
    end
    if (out_load) begin
      m_tuser <= out_status;
      m_tdata <= DATA_W'({out_due, out_id});
      m_tlast <= out_last;
    end
  end

`ifndef SYNTHESIS
  // valid cells always form an unbroken run from the head
  a_row_packed: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("queue row has a gap");

  // identifiers stay unique, so a probe hits at most one cell
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_hit))
    else $error("more than one cell matched");

  // time never runs backwards
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (cur_time >= $past(cur_time)))
    else $error("time counter went backwards");
`endif

endmodule

FILE: sim/timed_event_queue_test.sv
// ----------------------------------------------------------------------------
// Timed event queue testbench
// Sends add, cancel, cancel-all, tick and unused-mode words into the queue while
// both the sender and the receiver idle at random. A behavioral copy of the queue
// (sorted row plus time counter) predicts every result word, and the monitor
// compares each received word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module timed_event_queue_test;

  localparam int ID_W       = teq_pkg::ID_BITS_DEF;
  localparam int TIME_W     = teq_pkg::TIME_BITS_DEF;
  localparam int ROW_DEPTH  = teq_pkg::DEPTH_DEF;
  localparam int MODE_W     = teq_pkg::MODE_W;
  localparam int STATUS_W   = teq_pkg::STATUS_W;
  localparam int DATA_W     = ((ID_W + TIME_W + 7) / 8) * 8;
  localparam int RAND_WORDS = 280;
  localparam int CALM_TAIL  = 40;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 20;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tv;
    bit                drain;  // hold until every owed result is back
  } cmd_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] due;
  } slot_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   due;
    logic                last;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // event_id, time_value
  logic [MODE_W-1:0] s_tuser = '0;   // mode
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;        // event_id_res, due_time
  logic [STATUS_W-1:0] m_tuser;      // status
  logic              m_tlast;

  timed_event_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // pending stimulus and the shadow queue state
  cmd_t              cmd_q[$];
  cmd_t              cur_cmd;
  slot_t             shadow_row[$];
  logic [TIME_W-1:0] shadow_now = '0;
  outcome_t          owed_q[$];

  int  n_errors = 0;
  int  n_in = 0;
  int  n_out = 0;
  int  n_fired = 0;
  int  n_full = 0;
  int  n_dup = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  bit  all_sent = 1'b0;

  // generator bookkeeping
  int  gen_now = 0;
  int  gen_count = 0;
  bit  hold_next = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] tv);
    cmd_t c;
    c.mode = mode;
    c.id = id;
    c.tv = tv;
    c.drain = hold_next;
    hold_next = 1'b0;
    cmd_q.push_back(c);
    if (mode == teq_pkg::MODE_TICK) gen_now++;
    if (mode <= teq_pkg::MODE_TICK) gen_count++;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 85) return ID_W'($urandom_range(0, 23));
    return ID_W'($urandom_range(0, 255));
  endfunction

  function automatic void owe(input logic [STATUS_W-1:0] status, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] due, input logic last);
    outcome_t o;
    o.status = status;
    o.id = id;
    o.due = due;
    o.last = last;
    owed_q.push_back(o);
  endfunction

  function automatic int find_slot(input logic [ID_W-1:0] id);
    for (int i = 0; i < shadow_row.size(); i++)
      if (shadow_row[i].id == id) return i;
    return -1;
  endfunction

  // insert behind every entry due no later, so ties keep arrival order
  function automatic void schedule_event(input logic [ID_W-1:0] id,
                                         input logic [TIME_W-1:0] due);
    slot_t s;
    int    hit;
    int    pos;
    hit = find_slot(id);
    if (hit >= 0) begin
      owe(teq_pkg::STAT_DUPLICATE, id, shadow_row[hit].due, 1'b1);
    end else if (shadow_row.size() >= ROW_DEPTH) begin
      owe(teq_pkg::STAT_FULL, id, due, 1'b1);
    end else begin
      pos = 0;
      while (pos < shadow_row.size() && shadow_row[pos].due <= due) pos++;
      s.id = id;
      s.due = due;
      shadow_row.insert(pos, s);
      owe(teq_pkg::STAT_ADDED, id, due, 1'b1);
    end
  endfunction

  function automatic void apply_cmd(input cmd_t c);
    logic [TIME_W:0] sum;
    int              hit;
    bit              fired;
    case (c.mode)
      teq_pkg::MODE_ADD_AT: schedule_event(c.id, c.tv);
      teq_pkg::MODE_ADD_AFTER: begin
        sum = {1'b0, shadow_now} + {1'b0, c.tv};
        schedule_event(c.id, sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0]);
      end
      teq_pkg::MODE_CANCEL: begin
        hit = find_slot(c.id);
        if (hit < 0) begin
          owe(teq_pkg::STAT_NOT_FOUND, c.id, '0, 1'b1);
        end else begin
          owe(teq_pkg::STAT_CANCELLED, c.id, shadow_row[hit].due, 1'b1);
          shadow_row.delete(hit);
        end
      end
      teq_pkg::MODE_CANCEL_ALL: begin
        shadow_row.delete();
        owe(teq_pkg::STAT_NONE, '0, '0, 1'b1);
      end
      teq_pkg::MODE_TICK: begin
        if (shadow_now != {TIME_W{1'b1}}) shadow_now++;
        fired = 1'b0;
        while (shadow_row.size() > 0 && shadow_row[0].due <= shadow_now) begin
          owe(teq_pkg::STAT_FIRED, shadow_row[0].id, shadow_row[0].due,
              shadow_row.size() == 1 || shadow_row[1].due > shadow_now);
          void'(shadow_row.pop_front());
          fired = 1'b1;
        end
        if (!fired) owe(teq_pkg::STAT_NONE, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("MISMATCH result word %0d: %s got %0h expected %0h", n_out, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_cmd(cur_cmd);
        n_in++;
        if (cmd_q.size() == 0) all_sent = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 19);
      end
      calm = (cmd_q.size() < CALM_TAIL);
      if (s_tvalid && !s_tready) begin
        // hold the word until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (cmd_q.size() == 0 || (cmd_q[0].drain && owed_q.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        cur_cmd = cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {cur_cmd.tv, cur_cmd.id};
        s_tuser <= cur_cmd.mode;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (owed_q.size() == 0) begin
          report_mismatch("unexpected result, status", TIME_W'(m_tuser), '0);
        end else begin
          if (m_tuser != owed_q[0].status)
            report_mismatch("status", TIME_W'(m_tuser), TIME_W'(owed_q[0].status));
          if (m_tdata[ID_W-1:0] != owed_q[0].id)
            report_mismatch("event_id_res", TIME_W'(m_tdata[ID_W-1:0]),
                            TIME_W'(owed_q[0].id));
          if (m_tdata[ID_W +: TIME_W] != owed_q[0].due)
            report_mismatch("due_time", m_tdata[ID_W +: TIME_W], owed_q[0].due);
          if (m_tlast != owed_q[0].last)
            report_mismatch("last", TIME_W'(m_tlast), TIME_W'(owed_q[0].last));
          if (owed_q[0].status == teq_pkg::STAT_FIRED) n_fired++;
          if (owed_q[0].status == teq_pkg::STAT_FULL) n_full++;
          if (owed_q[0].status == teq_pkg::STAT_DUPLICATE) n_dup++;
          void'(owed_q.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // count cycles in which neither side moves a word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ID_W-1:0] base;
    int              pick;
    bit              mid_hold;
    bit              timed_out;

    mid_hold = 1'b0;
    timed_out = 1'b0;

    // directed part
    queue_cmd(teq_pkg::MODE_TICK, 8'h00, 32'h0);                 // nothing due
    queue_cmd(teq_pkg::MODE_CANCEL_ALL, 8'hA5, 32'hFFFF_FFFF);   // clear an empty row
    queue_cmd(teq_pkg::MODE_CANCEL, 8'h5A, 32'h0);               // not found
    queue_cmd(teq_pkg::MODE_ADD_AT, 8'h00, 32'h0);               // already passed
    queue_cmd(teq_pkg::MODE_ADD_AT, 8'hFF, 32'hFFFF_FFFF);
    queue_cmd(teq_pkg::MODE_ADD_AFTER, 8'h80, 32'hFFFF_FFFF);    // delay saturates
    queue_cmd(teq_pkg::MODE_ADD_AT, 8'h00, 32'h1234_5678);       // duplicate
    queue_cmd(teq_pkg::MODE_CANCEL, 8'hFF, 32'h0);
    queue_cmd(teq_pkg::MODE_ADD_AFTER, 8'h07, 32'd3);
    queue_cmd(teq_pkg::MODE_ADD_AT, 8'h08, 32'd4);               // tie with the one above
    queue_cmd(teq_pkg::MODE_TICK, 8'h00, 32'h0);
    for (int m = teq_pkg::MODE_TICK + 1; m < (1 << MODE_W); m++)
      queue_cmd(MODE_W'(m), ID_W'($urandom), $urandom);         // ignored modes
    for (int k = 0; k < 13; k++)
      queue_cmd(teq_pkg::MODE_ADD_AT, ID_W'(8'h10 + k), TIME_W'(k % 3));  // fills the row
    queue_cmd(teq_pkg::MODE_ADD_AT, 8'h33, 32'd9);               // full
    queue_cmd(teq_pkg::MODE_ADD_AFTER, 8'h07, 32'd1);            // duplicate wins over full
    queue_cmd(teq_pkg::MODE_TICK, 8'h00, 32'h0);
    queue_cmd(teq_pkg::MODE_CANCEL_ALL, 8'h00, 32'h0);

    // random part
    hold_next = 1'b1;
    while (gen_count < RAND_WORDS) begin
      if (gen_count >= RAND_WORDS / 2 && !mid_hold) begin
        hold_next = 1'b1;
        mid_hold = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // clear, fill the whole row with due events, then fire them in one tick
        queue_cmd(teq_pkg::MODE_CANCEL_ALL, ID_W'($urandom), $urandom);
        base = ID_W'($urandom);
        for (int k = 0; k < ROW_DEPTH; k++)
          queue_cmd(teq_pkg::MODE_ADD_AT, ID_W'(base + k),
                    TIME_W'($urandom_range(0, gen_now + 1)));
        queue_cmd(teq_pkg::MODE_TICK, ID_W'($urandom), $urandom);
      end else if (pick < 34) begin
        queue_cmd(teq_pkg::MODE_ADD_AT, pick_id(),
                  $urandom_range(0, 7) == 0 ? $urandom
                                            : TIME_W'(gen_now + $urandom_range(0, 12)));
      end else if (pick < 52) begin
        queue_cmd(teq_pkg::MODE_ADD_AFTER, pick_id(),
                  $urandom_range(0, 7) == 0 ? $urandom : TIME_W'($urandom_range(0, 12)));
      end else if (pick < 62) begin
        queue_cmd(teq_pkg::MODE_CANCEL, pick_id(), $urandom);
      end else if (pick < 65) begin
        queue_cmd(teq_pkg::MODE_CANCEL_ALL, ID_W'($urandom), $urandom);
      end else if (pick < 96) begin
        queue_cmd(teq_pkg::MODE_TICK, ID_W'($urandom), $urandom);
      end else begin
        queue_cmd(MODE_W'($urandom_range(teq_pkg::MODE_TICK + 1, (1 << MODE_W) - 1)),
                  ID_W'($urandom), $urandom);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (!(all_sent && owed_q.size() == 0)) begin
      @(posedge clk);
      if (idle_cycles >= IDLE_LIMIT) begin
        timed_out = 1'b1;
        break;
      end
    end

    if (timed_out) begin
      $display("Stuck for %0d cycles with %0d results owed", idle_cycles, owed_q.size());
      $display("Verification failed");
    end else begin
      repeat (DRAIN_WAIT) @(posedge clk);
      $display("Sent %0d command words, checked %0d result words (%0d fired events)",
               n_in, n_out, n_fired);
      $display("Rejections seen: %0d full, %0d duplicate; queue time reached %0d",
               n_full, n_dup, shadow_now);
      if (n_errors == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule

FILE: sim.f
src/teq_pkg.sv
src/teq_cell.sv
src/timed_event_queue.sv
sim/timed_event_queue_test.sv
